// ----- rtl/mvm_pkg.sv -----
// Shared types and constants for the matrix-vector multiply block.
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

  // Default sizing
  localparam int MAX_COLUMNS_DEF  = 256;
  localparam int ELEMENT_BITS_DEF = 16;

  // Fixed field widths
  localparam int ROW_W       = 16;
  localparam int COL_CNT_W   = 9;
  localparam int SUM_W       = 48;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  // Controller phases
  typedef enum logic [0:0] {
    ST_VECTOR,
    ST_MATRIX
  } mvm_state_t;

  // Per-word command from controller to datapath
  typedef struct packed {
    logic             write_vec;
    logic             mac;
    logic             first;
    logic             last;
    logic             last_row;
    logic [ROW_W-1:0] row_index;
  } mvm_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mvm_ctrl.sv -----
// Controller: configuration registers, phase state machine and position counters.
`timescale 1ns / 1ps
`default_nettype none

module mvm_ctrl #(
  parameter int MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF,
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [mvm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [mvm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                                 in_valid,
  input  wire                                 pipe_hold,
  output mvm_pkg::mvm_cmd_t                   cmd,
  output logic [COL_W-1:0]                    addr
);

  localparam int ROW_W = mvm_pkg::ROW_W;
  localparam int CNT_W = (COL_W + 1 > mvm_pkg::COL_CNT_W) ? COL_W + 1 : mvm_pkg::COL_CNT_W;

  mvm_pkg::mvm_state_t            state_r, state_nxt;
  logic [COL_W-1:0]               col_pos_r, col_pos_nxt;
  logic [ROW_W-1:0]               row_pos_r, row_pos_nxt;
  logic [ROW_W-1:0]               row_count_r;
  logic [mvm_pkg::COL_CNT_W-1:0]  column_count_r;

  logic             accept;
  logic [CNT_W-1:0] col_cnt_ext;
  logic [CNT_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic             col_end;
  logic             row_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_W'(1);
      column_count_r <= mvm_pkg::COL_CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mvm_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_wdata[ROW_W-1:0];
        mvm_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_wdata[mvm_pkg::COL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts to the usable range
  always_comb begin
    col_cnt_ext = CNT_W'(column_count_r);
    if (col_cnt_ext == '0) begin
      cols_eff = CNT_W'(1);
    end else if (col_cnt_ext > CNT_W'(MAX_COLUMNS)) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = col_cnt_ext;
    end
    rows_eff = (row_count_r == '0) ? ROW_W'(1) : row_count_r;
  end

  assign accept   = in_valid && !pipe_hold;
  assign col_end  = (CNT_W'(col_pos_r) + CNT_W'(1)) >= cols_eff;
  assign row_last = ({1'b0, row_pos_r} + 17'd1) >= {1'b0, rows_eff};
  assign addr     = col_pos_r;

  // Next state and position counters
  always_comb begin
    state_nxt   = state_r;
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (accept) begin
      if (!col_end) begin
        col_pos_nxt = col_pos_r + COL_W'(1);
      end else begin
        col_pos_nxt = '0;
        case (state_r)
          mvm_pkg::ST_VECTOR: begin
            state_nxt   = mvm_pkg::ST_MATRIX;
            row_pos_nxt = '0;
          end
          mvm_pkg::ST_MATRIX: begin
            if (row_last) begin
              state_nxt   = mvm_pkg::ST_VECTOR;
              row_pos_nxt = '0;
            end else begin
              row_pos_nxt = row_pos_r + ROW_W'(1);
            end
          end
          default: state_nxt = mvm_pkg::ST_VECTOR;
        endcase
      end
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.row_index = row_pos_r;
    cmd.first     = (col_pos_r == '0);
    cmd.last      = col_end;
    cmd.last_row  = row_last;
    case (state_r)
      mvm_pkg::ST_VECTOR: cmd.write_vec = accept;
      mvm_pkg::ST_MATRIX: cmd.mac       = accept;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mvm_pkg::ST_VECTOR;
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else begin
      state_r   <= state_nxt;
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  // A word is either stored or multiplied, never both
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.write_vec && cmd.mac))
    else $error("vector write and multiply issued together");

  // Last vector word moves to the matrix phase
  a_vec_to_mat: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && state_r == mvm_pkg::ST_VECTOR && col_end) |=> state_r == mvm_pkg::ST_MATRIX)
    else $error("vector phase did not end");

  // Last word of the last row returns to the vector phase with row reset
  a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && state_r == mvm_pkg::ST_MATRIX && col_end && row_last)
      |=> (state_r == mvm_pkg::ST_VECTOR && row_pos_r == '0))
    else $error("pass did not return to vector phase");

endmodule

`default_nettype wire

// ----- rtl/mvm_datapath.sv -----
// Datapath: vector memory, multiply pipeline, accumulator and output register.
`timescale 1ns / 1ps
`default_nettype none

module mvm_datapath #(
  parameter int MAX_COLUMNS  = mvm_pkg::MAX_COLUMNS_DEF,
  parameter int ELEMENT_BITS = mvm_pkg::ELEMENT_BITS_DEF,
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  mvm_pkg::mvm_cmd_t                     cmd,
  input  wire  [COL_W-1:0]                      addr,
  input  wire  signed [ELEMENT_BITS-1:0]        in_elem,
  output logic                                  pipe_hold,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [mvm_pkg::ROW_W-1:0]             out_row_index,
  output logic signed [mvm_pkg::SUM_W-1:0]      out_row_sum,
  output logic                                  out_last_row
);

  localparam int EB    = ELEMENT_BITS;
  localparam int SUM_W = mvm_pkg::SUM_W;
  localparam int ROW_W = mvm_pkg::ROW_W;

  logic [EB-1:0] vec_mem [MAX_COLUMNS];

  // Stage 1: element and vector read
  logic                 s1_valid_r;
  logic signed [EB-1:0] s1_elem_r;
  logic signed [EB-1:0] rd_r;
  logic                 s1_first_r, s1_last_r, s1_last_row_r;
  logic [ROW_W-1:0]     s1_row_r;

  // Stage 2: product
  logic                   s2_valid_r;
  logic signed [2*EB-1:0] prod_r;
  logic                   s2_first_r, s2_last_r, s2_last_row_r;
  logic [ROW_W-1:0]       s2_row_r;

  // Accumulator and output word
  logic signed [SUM_W-1:0] acc_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_last_r;

  logic adv;
  logic push;

  // Freeze the pipe only when a row end meets a held output word
  assign pipe_hold = out_valid_r && out_stall && s2_valid_r && s2_last_r;
  assign adv       = !pipe_hold;
  assign push      = adv && s2_valid_r && s2_last_r;
  assign sum_nxt   = (s2_first_r ? '0 : acc_r) + SUM_W'(prod_r);

  // Vector memory: write on vector words, registered read
  always_ff @(posedge clk) begin
    if (cmd.write_vec) begin
      vec_mem[addr] <= in_elem;
    end
    if (adv) begin
      rd_r <= vec_mem[addr];
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_elem_r     <= in_elem;
      s1_first_r    <= cmd.first;
      s1_last_r     <= cmd.last;
      s1_last_row_r <= cmd.last_row;
      s1_row_r      <= cmd.row_index;
    end
  end

  // Stage 2 payload: multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r        <= s1_elem_r * rd_r;
      s2_first_r    <= s1_first_r;
      s2_last_r     <= s1_last_r;
      s2_last_row_r <= s1_last_row_r;
      s2_row_r      <= s1_row_r;
    end
  end

  // Accumulate and load the output word at row end
  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      acc_r <= sum_nxt;
    end
    if (push) begin
      out_row_r  <= s2_row_r;
      out_sum_r  <= sum_nxt;
      out_last_r <= s2_last_row_r;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= cmd.mac;
        s2_valid_r <= s1_valid_r;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_row_sum   = out_sum_r;
  assign out_last_row  = out_last_r;

  // Hold only with a full, stalled output word
  a_hold_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_hold |-> (out_valid_r && out_stall))
    else $error("pipe held without a pending output word");

  // A new output word comes only from a row end in stage 2
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_last_r))
    else $error("output word without a row end");

  // Stage 1 advances into stage 2 when not held
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r) |=> s2_valid_r)
    else $error("multiply stage lost a word");

endmodule

`default_nettype wire

// ----- rtl/matrix_vector_multiply.sv -----
// A row's last matrix word goes through stage 1, the product and output registers to the result.
// Throughput: one word per cycle unless stalled, set by the memory read and product registers.
// The input stalls only while a row result waits on out_stall and the next row end arrives.
// Vector words are stored and give no result; each row gives one result word.
// Reset (rst_n low, synchronous) clears the phase to vector load, positions and valid flags.
// Row count and column count reset to 1; vector memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_multiply #(
  parameter int MAX_COLUMNS  = mvm_pkg::MAX_COLUMNS_DEF,
  parameter int ELEMENT_BITS = mvm_pkg::ELEMENT_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [mvm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [mvm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  signed [ELEMENT_BITS-1:0]      in_element_value,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [mvm_pkg::ROW_W-1:0]           out_row_index,
  output logic signed [mvm_pkg::SUM_W-1:0]    out_row_sum,
  output logic                                out_last_row
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  mvm_pkg::mvm_cmd_t cmd;
  logic [COL_W-1:0]  addr;
  logic              pipe_hold;

  mvm_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .pipe_hold (pipe_hold),
    .cmd       (cmd),
    .addr      (addr)
  );

  mvm_datapath #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .addr          (addr),
    .in_elem       (in_element_value),
    .pipe_hold     (pipe_hold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_row_sum   (out_row_sum),
    .out_last_row  (out_last_row)
  );

  assign in_stall = pipe_hold;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the streaming matrix-vector multiply block.
`timescale 1ns / 1ps

module tb_top;

  localparam int RESULT_LATENCY = 2;
  localparam int RANDOM_WORDS   = 1250;
  localparam int VEC_DEPTH      = mvm_pkg::MAX_COLUMNS_DEF;

  logic                                clk              = 1'b0;
  logic                                rst_n            = 1'b0;
  logic                                cfg_we           = 1'b0;
  logic [mvm_pkg::CFG_INDEX_W-1:0]     cfg_index        = '0;
  logic [mvm_pkg::CFG_DATA_W-1:0]      cfg_wdata        = '0;
  logic                                in_valid         = 1'b0;
  logic signed [15:0]                  in_element_value = '0;
  logic                                out_stall        = 1'b0;
  logic                                in_stall;
  logic                                out_valid;
  logic [mvm_pkg::ROW_W-1:0]           out_row_index;
  logic signed [mvm_pkg::SUM_W-1:0]    out_row_sum;
  logic                                out_last_row;

  always #10 clk = ~clk;

  matrix_vector_multiply uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_index    (out_row_index),
    .out_row_sum      (out_row_sum),
    .out_last_row     (out_last_row)
  );

  typedef struct {
    logic [mvm_pkg::ROW_W-1:0] row_index;
    logic [mvm_pkg::SUM_W-1:0] row_sum;
    logic                      last_row;
  } row_result_t;

  // Tracks the dot-product state and holds the row sums still owed by the block
  class mvm_scoreboard;
    logic [15:0]               vec_mem [VEC_DEPTH];
    bit                        vec_written [VEC_DEPTH];
    bit                        loading;
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [mvm_pkg::SUM_W-1:0] acc;
    logic [15:0]               rows_reg;
    logic [8:0]                cols_reg;
    row_result_t               owed_rows [$];
    int                        errors;

    function new();
      loading  = 1'b1;
      col_pos  = 0;
      row_pos  = 0;
      acc      = '0;
      rows_reg = 16'd1;
      cols_reg = 9'd1;
      errors   = 0;
      foreach (vec_written[i]) vec_written[i] = 1'b0;
    endfunction

    function void set_reg(logic [mvm_pkg::CFG_INDEX_W-1:0] idx,
                          logic [mvm_pkg::CFG_DATA_W-1:0] value);
      if (idx == mvm_pkg::REG_ROW_COUNT) rows_reg = value[15:0];
      else if (idx == mvm_pkg::REG_COLUMN_COUNT) cols_reg = value[8:0];
    endfunction

    function int unsigned active_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > VEC_DEPTH) return VEC_DEPTH;
      return cols_reg;
    endfunction

    // Longest run of written vector entries from column zero
    function int unsigned written_prefix();
      int unsigned n;
      n = 0;
      while (n < VEC_DEPTH && vec_written[n]) n++;
      return n;
    endfunction

    function bit at_pass_start();
      return loading && col_pos == 0;
    endfunction

    function int pending();
      return owed_rows.size();
    endfunction

    // Advance the model by one accepted word
    function void note_word(logic [15:0] word);
      int unsigned        ncols;
      int unsigned        nrows;
      bit                 row_end;
      logic signed [15:0] a;
      logic signed [15:0] x;
      logic signed [31:0] prod;
      row_result_t        r;
      ncols   = active_cols();
      nrows   = (rows_reg == 0) ? 1 : rows_reg;
      row_end = (col_pos + 1 >= ncols);
      if (loading) begin
        if (col_pos < VEC_DEPTH) begin
          vec_mem[col_pos]     = word;
          vec_written[col_pos] = 1'b1;
        end
        if (row_end) begin
          col_pos = 0;
          loading = 1'b0;
          row_pos = 0;
          acc     = '0;
        end else begin
          col_pos++;
        end
        return;
      end
      a    = word;
      x    = (col_pos < VEC_DEPTH) ? vec_mem[col_pos] : '0;
      prod = a * x;
      acc  = acc + {{(mvm_pkg::SUM_W-32){prod[31]}}, prod};
      if (!row_end) begin
        col_pos++;
        return;
      end
      r.row_index = row_pos[15:0];
      r.row_sum   = acc;
      r.last_row  = (row_pos + 1 >= nrows);
      owed_rows.push_back(r);
      col_pos = 0;
      acc     = '0;
      if (r.last_row) begin
        row_pos = 0;
        loading = 1'b1;
      end else begin
        row_pos = (row_pos + 1) & 16'hFFFF;
      end
    endfunction

    // Compare one accepted result word with the oldest owed row
    function void check_result(logic [mvm_pkg::ROW_W-1:0] idx,
                               logic [mvm_pkg::SUM_W-1:0] sum, logic last);
      row_result_t r;
      if (owed_rows.size() == 0) begin
        $error("unexpected result word: row_index %0d row_sum %0d", idx, $signed(sum));
        errors++;
        return;
      end
      r = owed_rows.pop_front();
      if (idx !== r.row_index) begin
        $error("row_index mismatch: expected %0d actual %0d", r.row_index, idx);
        errors++;
      end
      if (sum !== r.row_sum) begin
        $error("row_sum mismatch: expected %0d actual %0d", $signed(r.row_sum), $signed(sum));
        errors++;
      end
      if (last !== r.last_row) begin
        $error("last_row mismatch: expected %0d actual %0d", r.last_row, last);
        errors++;
      end
    endfunction
  endclass

  mvm_scoreboard board = new();

  // Receiver: check accepted words, then pick the next stall value
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_row_index, out_row_sum, out_last_row);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((mode_left % 16) < 10);
    endcase
  end

  // Sender bookkeeping
  int burst_left = 0;
  bit driving    = 1'b0;

  task automatic send_word(input logic [15:0] word);
    in_valid         <= 1'b1;
    in_element_value <= word;
    driving = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(word);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      driving = 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 20);
    end
  endtask

  // Hold off input until every owed row has come out, then let the pipe empty
  task automatic settle();
    if (driving) begin
      in_valid <= 1'b0;
      driving = 1'b0;
    end
    while (board.pending() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mvm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mvm_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_element();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Column count word, sometimes with junk above the nine used bits
  function automatic logic [mvm_pkg::CFG_DATA_W-1:0] cols_word(input int unsigned cols);
    logic [8:0] c;
    c = cols[8:0];
    if ($urandom_range(0, 3) == 0) return {7'($urandom), c};
    return {7'd0, c};
  endfunction

  initial begin
    int          sent;
    int unsigned rows;
    int unsigned cols;
    int unsigned pick;
    int unsigned limit;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: one row, one column
    send_word(16'h7FFF);
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_word(16'h8000);

    // Zero counts fall back to one
    settle();
    write_reg(mvm_pkg::REG_COLUMN_COUNT, 16'd0);
    write_reg(mvm_pkg::REG_ROW_COUNT, 16'd0);
    send_word(16'h8000);
    send_word(16'h7FFF);

    // Three columns with extreme elements
    settle();
    write_reg(mvm_pkg::REG_COLUMN_COUNT, 16'd3);
    write_reg(mvm_pkg::REG_ROW_COUNT, 16'd1);
    send_word(16'h8000);
    send_word(16'h7FFF);
    send_word(16'hFFFF);
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_word(16'hFFFF);

    // Maximum row count, then shrink both counts in the middle of the pass
    settle();
    write_reg(mvm_pkg::REG_COLUMN_COUNT, 16'd4);
    write_reg(mvm_pkg::REG_ROW_COUNT, 16'hFFFF);
    repeat (8) send_word(rand_element());
    repeat (2) send_word(rand_element());
    settle();
    // column position is already past the new count: next word closes the row
    write_reg(mvm_pkg::REG_COLUMN_COUNT, 16'd2);
    send_word(rand_element());
    settle();
    // row position is past the new count: next row is the last
    write_reg(mvm_pkg::REG_ROW_COUNT, 16'd2);
    write_reg(mvm_pkg::REG_COLUMN_COUNT, 16'hFE04);
    repeat (4) send_word(rand_element());

    // Random passes with occasional mid-pass register changes
    sent = 0;
    while (!(sent >= RANDOM_WORDS && board.at_pass_start())) begin
      if (board.at_pass_start() && $urandom_range(0, 2) != 0) begin
        settle();
        pick = $urandom_range(0, 49);
        if (pick == 0) cols = 0;
        else if (pick == 1) cols = $urandom_range(257, 511);
        else if (pick == 2) cols = 256;
        else if (pick < 6) cols = $urandom_range(9, 64);
        else cols = $urandom_range(1, 8);
        pick = $urandom_range(0, 9);
        if (pick == 0) rows = 0;
        else if (pick == 1) rows = $urandom_range(12, 20);
        else rows = $urandom_range(1, 6);
        if (cols > 64) rows = $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 0) begin
          write_reg(mvm_pkg::REG_ROW_COUNT, 16'(rows));
          write_reg(mvm_pkg::REG_COLUMN_COUNT, cols_word(cols));
        end else begin
          write_reg(mvm_pkg::REG_COLUMN_COUNT, cols_word(cols));
          write_reg(mvm_pkg::REG_ROW_COUNT, 16'(rows));
        end
      end else if (!board.at_pass_start() && $urandom_range(0, 199) == 0) begin
        settle();
        if ($urandom_range(0, 1) == 0) begin
          write_reg(mvm_pkg::REG_ROW_COUNT, 16'($urandom_range(0, 8)));
        end else begin
          // never raise past the written part of the vector store
          limit = board.loading ? 40 : board.written_prefix();
          if (limit > 40) limit = 40;
          write_reg(mvm_pkg::REG_COLUMN_COUNT, cols_word($urandom_range(0, limit)));
        end
      end
      send_word(rand_element());
      sent++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mvm_pkg.sv
rtl/mvm_ctrl.sv
rtl/mvm_datapath.sv
rtl/matrix_vector_multiply.sv
test/tb_top.sv
